/* rtl/core/tun_pkg.sv */
// Package for the triangle unit normal block: word types and fixed widths.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package tun_pkg;

   localparam int CoordWidth = 24;
   localparam int NormWidth  = 32;
   localparam int MagWidth   = 30;   // prenormalized magnitude width
   localparam int SumWidth   = 62;   // sum of three squares stays below 2^62
   localparam int QBits      = 31;   // result magnitude bits (q <= 2^30)
   localparam int ScaleShift = 62;   // 4 * 2^60 on the m^2 side of the test
   localparam int RemWidth   = 128;  // signed remainder and step terms

   typedef struct packed {
      logic signed [CoordWidth-1:0] p1_x;
      logic signed [CoordWidth-1:0] p1_y;
      logic signed [CoordWidth-1:0] p1_z;
      logic signed [CoordWidth-1:0] p2_x;
      logic signed [CoordWidth-1:0] p2_y;
      logic signed [CoordWidth-1:0] p2_z;
      logic signed [CoordWidth-1:0] p3_x;
      logic signed [CoordWidth-1:0] p3_y;
      logic signed [CoordWidth-1:0] p3_z;
   } req_word_type;

   typedef struct packed {
      logic signed [NormWidth-1:0] normal_x;
      logic signed [NormWidth-1:0] normal_y;
      logic signed [NormWidth-1:0] normal_z;
      logic                        degenerate;
   } rsp_word_type;

   // Per-component state carried through the rounding pipeline:
   // r = 4 m^2 2^60 - (2q-1)^2 s, p = (2q-1) s
   typedef struct packed {
      logic [QBits-1:0]           q;
      logic                       neg;
      logic signed [RemWidth-1:0] r;
      logic signed [RemWidth-1:0] p;
   } comp_type;

endpackage
`default_nettype wire

/* rtl/core/triangle_unit_normal.sv */
// Top level of the triangle unit normal pipeline.
// Depends on tun_pkg and tun_qstage.
`timescale 1ns / 1ps
`default_nettype none
// Takes one triangle per cycle while the output is not stalled and returns its
// unit normal (signed Q1.30, rounded to nearest) through 39 register stages:
// difference, cross product multiply, cross product subtract, magnitude and
// shift amount, shift, squares and sum, remainder setup, then 31 stages of the
// rounded square-root division, one result bit per stage, and the output
// register. A zero cross product sets degenerate and yields zero components.
// The whole pipeline advances when the output word is not stalled, so the
// throughput is one word per cycle and a stalled output holds the input for
// as long.
module triangle_unit_normal (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output      logic                  req_stall,
   input  wire tun_pkg::req_word_type req_data,
   output      logic                  rsp_valid,
   input  wire logic                  rsp_stall,
   output      tun_pkg::rsp_word_type rsp_data
);
   import tun_pkg::*;

   localparam int Pre = 7;            // stages before the bit search
   localparam int Depth = Pre + QBits;

   logic adv;
   logic [Depth-1:0] vld_ff;
   logic [Depth-1:0] vld_in;

   // valid shift line; pipeline moves when the output is free
   assign adv = !(rsp_valid && rsp_stall);
   assign req_stall = !adv;
   assign vld_in = {vld_ff[Depth-2:0], req_valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff    <= '0;
         rsp_valid <= 1'b0;
      end else if (adv) begin
         vld_ff    <= vld_in;
         rsp_valid <= vld_ff[Depth-1];
      end
   end

   // stage 1: edge vectors
   logic signed [24:0] a_ff [3];
   logic signed [24:0] b_ff [3];
   always_ff @(posedge clock) begin
      if (adv) begin
         a_ff[0] <= 25'(req_data.p2_x) - 25'(req_data.p1_x);
         a_ff[1] <= 25'(req_data.p2_y) - 25'(req_data.p1_y);
         a_ff[2] <= 25'(req_data.p2_z) - 25'(req_data.p1_z);
         b_ff[0] <= 25'(req_data.p3_x) - 25'(req_data.p2_x);
         b_ff[1] <= 25'(req_data.p3_y) - 25'(req_data.p2_y);
         b_ff[2] <= 25'(req_data.p3_z) - 25'(req_data.p2_z);
      end
   end

   // stage 2: six partial products
   logic signed [49:0] pp_ff [6];
   always_ff @(posedge clock) begin
      if (adv) begin
         pp_ff[0] <= a_ff[1] * b_ff[2];
         pp_ff[1] <= a_ff[2] * b_ff[1];
         pp_ff[2] <= a_ff[2] * b_ff[0];
         pp_ff[3] <= a_ff[0] * b_ff[2];
         pp_ff[4] <= a_ff[0] * b_ff[1];
         pp_ff[5] <= a_ff[1] * b_ff[0];
      end
   end

   // stage 3: cross product
   logic signed [50:0] c_ff [3];
   always_ff @(posedge clock) begin
      if (adv) begin
         c_ff[0] <= 51'(pp_ff[0]) - 51'(pp_ff[1]);
         c_ff[1] <= 51'(pp_ff[2]) - 51'(pp_ff[3]);
         c_ff[2] <= 51'(pp_ff[4]) - 51'(pp_ff[5]);
      end
   end

   // stage 4: magnitudes, signs, shift amount
   logic [50:0] mag_ff [3];
   logic [2:0]  neg_ff;
   logic [4:0]  k_ff;
   logic        deg4_ff;
   logic [50:0] mag_c [3];
   logic [50:0] orm;
   logic [4:0]  k_c;
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         mag_c[i] = c_ff[i][50] ? 51'(-c_ff[i]) : 51'(c_ff[i]);
      end
      orm = mag_c[0] | mag_c[1] | mag_c[2];
      k_c = '0;
      for (int j = 0; j < 21; j++) begin
         if (orm[30+j]) begin
            k_c = 5'(j + 1);
         end
      end
   end
   always_ff @(posedge clock) begin
      if (adv) begin
         for (int i = 0; i < 3; i++) begin
            mag_ff[i]    <= mag_c[i];
            neg_ff[i]    <= c_ff[i][50];
         end
         k_ff    <= k_c;
         deg4_ff <= (orm == '0);
      end
   end

   // stage 5: shifted magnitudes
   logic [MagWidth-1:0] m5_ff [3];
   logic [2:0]          neg5_ff;
   logic                deg5_ff;
   always_ff @(posedge clock) begin
      if (adv) begin
         for (int i = 0; i < 3; i++) begin
            m5_ff[i] <= MagWidth'(mag_ff[i] >> k_ff);
         end
         neg5_ff <= neg_ff;
         deg5_ff <= deg4_ff;
      end
   end

   // stage 6: squares and their sum
   logic [2*MagWidth-1:0] msq_c   [3];
   logic [2*MagWidth-1:0] msq6_ff [3];
   logic [2:0]            neg6_ff;
   logic [SumWidth-1:0]   s_ff;
   logic                  deg6_ff;
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         msq_c[i] = m5_ff[i] * m5_ff[i];
      end
   end
   always_ff @(posedge clock) begin
      if (adv) begin
         msq6_ff <= msq_c;
         s_ff    <= SumWidth'(msq_c[0]) + SumWidth'(msq_c[1]) + SumWidth'(msq_c[2]);
         neg6_ff <= neg6_ff_in_unused_guard(neg5_ff);
         deg6_ff <= deg5_ff;
      end
   end

   function automatic logic [2:0] neg6_ff_in_unused_guard(logic [2:0] v);
      return v;
   endfunction

   // stage 7: remainder setup for q = 0
   comp_type            ci_ff [3];
   logic [SumWidth-1:0] s7_ff;
   logic                deg7_ff;
   always_ff @(posedge clock) begin
      if (adv) begin
         for (int i = 0; i < 3; i++) begin
            ci_ff[i].q   <= '0;
            ci_ff[i].neg <= neg6_ff[i];
            ci_ff[i].r   <= RemWidth'({msq6_ff[i], {ScaleShift{1'b0}}})
                          - RemWidth'(s_ff);
            ci_ff[i].p   <= -RemWidth'(s_ff);
         end
         s7_ff   <= s_ff;
         deg7_ff <= deg6_ff;
      end
   end

   // bit search stages, one result bit per stage
   comp_type            cq  [QBits+1][3];
   logic [SumWidth-1:0] sq  [QBits+1];
   logic                dq  [QBits+1];
   assign cq[0] = ci_ff;
   assign sq[0] = s7_ff;
   assign dq[0] = deg7_ff;

   for (genvar g = 0; g < QBits; g++) begin : g_bit
      logic [SumWidth-1:0] s_ff_g;
      logic                d_ff_g;
      always_ff @(posedge clock) begin
         if (adv) begin
            s_ff_g <= sq[g];
            d_ff_g <= dq[g];
         end
      end
      assign sq[g+1] = s_ff_g;
      assign dq[g+1] = d_ff_g;
      for (genvar i = 0; i < 3; i++) begin : g_comp
         tun_qstage #(.Bit(QBits - 1 - g)) u_stage (
            .clock    (clock),
            .enable   (adv),
            .s        (sq[g]),
            .comp_in  (cq[g][i]),
            .comp_out (cq[g+1][i])
         );
      end
   end

   // output register: apply sign, zero on degenerate
   logic signed [NormWidth-1:0] nrm [3];
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         nrm[i] = cq[QBits][i].neg ? -NormWidth'(cq[QBits][i].q)
                                   : NormWidth'(cq[QBits][i].q);
         if (dq[QBits]) begin
            nrm[i] = '0;
         end
      end
   end
   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_data.normal_x   <= nrm[0];
         rsp_data.normal_y   <= nrm[1];
         rsp_data.normal_z   <= nrm[2];
         rsp_data.degenerate <= dq[QBits];
      end
   end

endmodule
`default_nettype wire

/* rtl/core/tun_qstage.sv */
// One bit step of the exact rounded scaled-magnitude search, registered.
// Depends on tun_pkg.
`timescale 1ns / 1ps
`default_nettype none
module tun_qstage #(
   parameter int Bit = 30
) (
   input  wire logic                        clock,
   input  wire logic                        enable,
   input  wire logic [tun_pkg::SumWidth-1:0] s,
   input  wire tun_pkg::comp_type           comp_in,
   output tun_pkg::comp_type                comp_out
);
   import tun_pkg::*;

   logic signed [RemWidth-1:0] s_w;
   logic signed [RemWidth-1:0] diff;
   comp_type comp_in_c;
   comp_type comp_ff;

   // accept bit if (2t-1)^2 * s <= m^2 * 2^62, t = q + 2^Bit;
   // growth of (2q-1)^2 s is 2^(Bit+2) p + 2^(2Bit+2) s
   always_comb begin
      comp_in_c = comp_in;
      s_w  = RemWidth'(s);
      diff = comp_in.r - (comp_in.p <<< (Bit + 2)) - (s_w <<< (2*Bit + 2));
      if (!diff[RemWidth-1]) begin
         comp_in_c.q = comp_in.q | (QBits'(1) << Bit);
         comp_in_c.r = diff;
         comp_in_c.p = comp_in.p + (s_w <<< (Bit + 1));
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         comp_ff <= comp_in_c;
      end
   end

   assign comp_out = comp_ff;

endmodule
`default_nettype wire

/* test/testbench.sv */
// Testbench for triangle_unit_normal: drives random and directed triangles and
// checks each unit normal against an exact integer predictor. Depends on tun_pkg.
`timescale 1ns / 1ps
module testbench;
   import tun_pkg::*;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_stall;
   req_word_type req_data = '0;
   logic         rsp_valid;
   logic         rsp_stall = 1'b0;
   rsp_word_type rsp_data;

   rsp_word_type normal_queue[$];
   int  error_count = 0;
   int  sent_count = 0;
   int  checked_count = 0;
   int  degenerate_count = 0;
   int  cycle_count = 0;
   int  send_idle_pct = 0;
   int  stall_pct = 0;
   localparam int Latency = 38;
   localparam int CycleLimit = 400000;

   triangle_unit_normal dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   // timeout
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CycleLimit) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   // rounded magnitude: largest q with (2q-1)^2 * s <= 4 m^2 2^60
   function automatic logic [30:0] round_mag(logic [29:0] m, logic [61:0] s);
      logic [30:0]  q;
      logic [30:0]  t;
      logic [127:0] lhs;
      logic [127:0] rhs;
      q = '0;
      rhs = ({98'd0, m} * {98'd0, m}) << 62;
      for (int bit_idx = 30; bit_idx >= 0; bit_idx--) begin
         t = q | (31'd1 << bit_idx);
         lhs = ({96'd0, t, 1'b0} - 128'd1);
         lhs = lhs * lhs * {66'd0, s};
         if (lhs <= rhs) q = t;
      end
      return q;
   endfunction

   function automatic rsp_word_type predict_normal(req_word_type w);
      rsp_word_type r;
      logic signed [63:0] a[3], b[3], c[3];
      logic [63:0] mag[3];
      logic [63:0] big;
      logic [61:0] sum;
      logic [30:0] q;
      int k;
      a[0] = 64'(w.p2_x) - 64'(w.p1_x);
      a[1] = 64'(w.p2_y) - 64'(w.p1_y);
      a[2] = 64'(w.p2_z) - 64'(w.p1_z);
      b[0] = 64'(w.p3_x) - 64'(w.p2_x);
      b[1] = 64'(w.p3_y) - 64'(w.p2_y);
      b[2] = 64'(w.p3_z) - 64'(w.p2_z);
      c[0] = a[1] * b[2] - a[2] * b[1];
      c[1] = a[2] * b[0] - a[0] * b[2];
      c[2] = a[0] * b[1] - a[1] * b[0];
      r = '0;
      if (c[0] == 0 && c[1] == 0 && c[2] == 0) begin
         r.degenerate = 1'b1;
         return r;
      end
      big = 0;
      for (int i = 0; i < 3; i++) begin
         mag[i] = c[i] < 0 ? 64'(-c[i]) : 64'(c[i]);
         if (mag[i] > big) big = mag[i];
      end
      k = 0;
      while ((big >> k) >= 64'd1 << 30) k++;
      sum = 0;
      for (int i = 0; i < 3; i++) begin
         mag[i] = mag[i] >> k;
         sum = sum + 62'(mag[i] * mag[i]);
      end
      for (int i = 0; i < 3; i++) begin
         q = round_mag(mag[i][29:0], sum);
         if (i == 0) r.normal_x = c[i] < 0 ? -32'(q) : 32'(q);
         if (i == 1) r.normal_y = c[i] < 0 ? -32'(q) : 32'(q);
         if (i == 2) r.normal_z = c[i] < 0 ? -32'(q) : 32'(q);
      end
      return r;
   endfunction

   // receiver stall pattern
   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(99) < stall_pct);
   end

   // result checker
   always @(posedge clock) begin
      rsp_word_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (normal_queue.size() == 0) begin
            $display("%0t unexpected word: expected none, actual %h", $time, rsp_data);
            error_count++;
         end else begin
            want = normal_queue.pop_front();
            checked_count++;
            if (want.degenerate) degenerate_count++;
            if (want.normal_x !== rsp_data.normal_x) begin
               $display("%0t normal_x: expected %0d actual %0d", $time,
                        want.normal_x, rsp_data.normal_x);
               error_count++;
            end
            if (want.normal_y !== rsp_data.normal_y) begin
               $display("%0t normal_y: expected %0d actual %0d", $time,
                        want.normal_y, rsp_data.normal_y);
               error_count++;
            end
            if (want.normal_z !== rsp_data.normal_z) begin
               $display("%0t normal_z: expected %0d actual %0d", $time,
                        want.normal_z, rsp_data.normal_z);
               error_count++;
            end
            if (want.degenerate !== rsp_data.degenerate) begin
               $display("%0t degenerate: expected %0b actual %0b", $time,
                        want.degenerate, rsp_data.degenerate);
               error_count++;
            end
         end
      end
   end

   // send one word, holding it until accepted
   task automatic send_triangle(req_word_type w);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= w;
      normal_queue.push_back(predict_normal(w));
      sent_count++;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   task automatic idle_line();
      req_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic drain();
      idle_line();
      while (normal_queue.size() != 0) @(posedge clock);
   endtask

   function automatic logic [23:0] rand_coord();
      case ($urandom_range(5))
         0: return 24'h800000;
         1: return 24'h7fffff;
         2: return 24'($urandom_range(15)) - 24'd8;
         default: return 24'($urandom);
      endcase
   endfunction

   function automatic req_word_type make_tri(logic [23:0] v[9]);
      return {v[0], v[1], v[2], v[3], v[4], v[5], v[6], v[7], v[8]};
   endfunction

   task automatic test_directed();
      logic [23:0] v[9];
      logic [23:0] lo, hi;
      lo = 24'h800000;
      hi = 24'h7fffff;
      // coincident points
      v = '{default: 24'd0};
      send_triangle(make_tri(v));
      v = '{default: hi};
      send_triangle(make_tri(v));
      // collinear points
      v = '{24'd0, 24'd0, 24'd0, 24'd1, 24'd1, 24'd1, 24'd2, 24'd2, 24'd2};
      send_triangle(make_tri(v));
      // axis-aligned right triangles, both windings
      v = '{24'd0, 24'd0, 24'd0, 24'd4096, 24'd0, 24'd0, 24'd0, 24'd4096, 24'd0};
      send_triangle(make_tri(v));
      v = '{24'd0, 24'd0, 24'd0, 24'd0, 24'd4096, 24'd0, 24'd4096, 24'd0, 24'd0};
      send_triangle(make_tri(v));
      v = '{24'd0, 24'd0, 24'd0, 24'd0, 24'd1, 24'd0, 24'd0, 24'd0, 24'd1};
      send_triangle(make_tri(v));
      // equal components
      v = '{24'd1, 24'd0, 24'd0, 24'd0, 24'd1, 24'd0, 24'd0, 24'd0, 24'd1};
      send_triangle(make_tri(v));
      // extreme spans, largest cross product
      v = '{lo, lo, lo, hi, lo, lo, hi, hi, lo};
      send_triangle(make_tri(v));
      v = '{lo, lo, lo, hi, hi, lo, lo, hi, hi};
      send_triangle(make_tri(v));
      v = '{hi, lo, hi, lo, hi, lo, hi, hi, lo};
      send_triangle(make_tri(v));
      v = '{lo, hi, lo, hi, lo, hi, lo, lo, hi};
      send_triangle(make_tri(v));
      // tiny and skewed
      v = '{24'd0, 24'd0, 24'd0, 24'd1, 24'd0, 24'd0, hi, 24'd1, 24'd0};
      send_triangle(make_tri(v));
      v = '{24'd5, 24'hfffffd, 24'd7, 24'd6, 24'hfffffd, 24'd9, 24'd3, 24'd1, 24'd0};
      send_triangle(make_tri(v));
      drain();
   endtask

   task automatic test_random(int count, int idle, int stall);
      logic [23:0] v[9];
      send_idle_pct = idle;
      stall_pct = stall;
      for (int n = 0; n < count; n++) begin
         for (int i = 0; i < 9; i++) v[i] = rand_coord();
         // some collinear or repeated points
         if ($urandom_range(19) == 0) begin
            for (int i = 0; i < 3; i++) v[6+i] = v[3+i];
         end else if ($urandom_range(19) == 0) begin
            for (int i = 0; i < 3; i++) v[6+i] = 24'(2 * v[3+i] - v[i]);
         end
         send_triangle(make_tri(v));
      end
      drain();
      stall_pct = 0;
      send_idle_pct = 0;
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_random(400, 0, 0);
      test_random(380, 50, 0);
      test_random(380, 0, 50);
      test_random(380, 36, 36);
      repeat (Latency + 8) @(posedge clock);
      $display("Covered %0d triangles, %0d normals checked, %0d degenerate.",
               sent_count, checked_count, degenerate_count);
      if (error_count == 0 && normal_queue.size() == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end
endmodule
